@@ rtl/htd_pkg.sv @@
// shared types and constants for the huffman table bit decoder
package htd_pkg;

  localparam int TABLE_DEPTH   = 256;
  localparam int IDX_W         = $clog2(TABLE_DEPTH);
  localparam int MAX_CODE_BITS = 16;
  localparam int LEN_W         = 5;
  localparam int BYTE_BITS     = 8;
  localparam int CNT_W         = 4;

  // input word, fields in channel order
  typedef struct packed {
    logic             cmd;
    logic [7:0]       entry_index;
    logic [7:0]       entry_symbol;
    logic [LEN_W-1:0] entry_length;
    logic [15:0]      entry_code;
    logic [7:0]       code_byte;
    logic [CNT_W-1:0] bit_count;
    logic             end_of_message;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [7:0] symbol;
    logic       message_end;
    logic       code_overflow;
    logic       last;
  } out_word_t;

  // one code table entry
  typedef struct packed {
    logic [7:0]       symbol;
    logic [LEN_W-1:0] length;
    logic [15:0]      code;
  } entry_t;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_DECODE,
    OP_NONE
  } op_kind_t;

  localparam logic CMD_LOAD = 1'b0;

  // classified operation handed from front to back
  typedef struct packed {
    op_kind_t         kind;
    logic [IDX_W-1:0] index;
    entry_t           entry;
    logic [7:0]       code_byte;
    logic [CNT_W-1:0] bit_count;
    logic             eom;
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NEXT_BIT,
    ST_SCAN,
    ST_EMIT,
    ST_FLUSH
  } back_state_t;

endpackage

@@ rtl/huffman_table_bit_decoder.sv @@
// top level of the huffman table bit decoder
//
// input channel: a word is taken when push is high and full is low. a word
// with cmd low writes one code table slot (symbol, length, code) and gives
// no result. a word with cmd high carries an encoded byte whose leading
// bit_count bits (clamped to eight) are decoded msb first; end_of_message
// then drops any partial code and adds an end marker result.
// result channel: while empty is low the oldest result sits on out_word and
// is taken when pop is high. last marks the final result of a word.
// timing: the front queue holds two words, so push keeps working while the
// back end is busy. the back end writes a table load as it takes it. for
// each decoded bit the slot scan of the table memory, which reads one slot
// at a time, sets the pace: the scan runs from slot 1 up to the match, the
// first zero symbol or the last slot. each result waits in the back end
// until the next one forms or the word ends, then enters the result queue
// and shows on out_word in the cycle after.
// reset: the table reads as empty at once (per-slot valid flags), the code
// accumulator and both queues are cleared, no clearing pass is needed.
// stalls: when pop stays low the two-word result queue fills, the back end
// waits, then the front queue fills and full goes high.
module huffman_table_bit_decoder
  import htd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  // input channel
  input  logic      push,
  output logic      full,
  input  in_word_t  in_word,
  // result channel
  output logic      empty,
  input  logic      pop,
  output out_word_t out_word
);

  // front to back operation hand-off
  logic      op_valid;
  op_t       op;
  logic      op_pop;

  // back to result queue
  logic      q_push;
  out_word_t q_word;
  logic      q_full;

  // accept and classify input words
  htd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_word  (in_word),
    .op_valid (op_valid),
    .op       (op),
    .op_pop   (op_pop)
  );

  // table store and bit-by-bit scan
  htd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_valid (op_valid),
    .op       (op),
    .op_pop   (op_pop),
    .q_push   (q_push),
    .q_word   (q_word),
    .q_full   (q_full)
  );

  // result buffering toward the consumer
  htd_out_q u_out_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_push   (q_push),
    .q_word   (q_word),
    .q_full   (q_full),
    .empty    (empty),
    .pop      (pop),
    .out_word (out_word)
  );

endmodule

@@ rtl/htd_front.sv @@
// front end: accepts input words, classifies them and queues operations
module htd_front
  import htd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  in_word_t in_word,
  output logic     op_valid,
  output op_t      op,
  input  logic     op_pop
);

  op_t        q_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_push;
  logic       do_pop;
  op_t        op_new;

  function automatic op_t classify(input in_word_t w);
    op_t o;
    o.index     = IDX_W'(w.entry_index);
    o.entry     = '{symbol: w.entry_symbol, length: w.entry_length, code: w.entry_code};
    o.code_byte = w.code_byte;
    // counts above a byte clamp to a byte
    o.bit_count = (w.bit_count > CNT_W'(BYTE_BITS)) ? CNT_W'(BYTE_BITS) : w.bit_count;
    o.eom       = w.end_of_message;
    if (w.cmd == CMD_LOAD) begin
      o.kind = (32'(w.entry_index) < TABLE_DEPTH) ? OP_LOAD : OP_NONE;
    end else begin
      o.kind = OP_DECODE;
    end
    return o;
  endfunction

  assign op_new   = classify(in_word);
  assign full     = (cnt_r == 2'd2);
  assign op_valid = (cnt_r != 2'd0);
  assign op       = q_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = op_pop && op_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= op_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

@@ rtl/htd_out_q.sv @@
// two-word result queue
module htd_out_q
  import htd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_push,
  input  out_word_t q_word,
  output logic      q_full,
  output logic      empty,
  input  logic      pop,
  output out_word_t out_word
);

  out_word_t  q_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_push;
  logic       do_pop;

  assign q_full   = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign out_word = q_r[rd_ptr_r];
  assign do_push  = q_push && !q_full;
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= q_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

@@ rtl/htd_back.sv @@
// back end: code table memory and the per-bit table scan sequencer
module htd_back
  import htd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      op_valid,
  input  op_t       op,
  output logic      op_pop,
  output logic      q_push,
  output out_word_t q_word,
  input  logic      q_full
);

  entry_t                   mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]   vld_r;
  entry_t                   rd_data_r;
  logic                     rd_vld_r;
  logic [IDX_W-1:0]         rd_addr;
  logic                     wr_en;
  entry_t                   cur;

  back_state_t              state_r, state_nxt;
  logic [MAX_CODE_BITS-1:0] acc_r, acc_nxt;
  logic [LEN_W-1:0]         len_r, len_nxt;
  logic [BYTE_BITS-1:0]     byte_r, byte_nxt;
  logic [CNT_W-1:0]         left_r, left_nxt;
  logic                     eom_r, eom_nxt;
  logic [IDX_W-1:0]         slot_r, slot_nxt;
  out_word_t                res_r, res_nxt;
  out_word_t                pend_r, pend_nxt;
  logic                     pend_vld_r, pend_vld_nxt;
  logic                     hit;
  logic                     stop;

  // table memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[op.index] <= op.entry;
    end
    rd_data_r <= mem[rd_addr];
    rd_vld_r  <= vld_r[rd_addr];
  end

  // never-written slots read as an all-zero entry
  assign cur  = rd_vld_r ? rd_data_r : '0;
  assign hit  = (cur.symbol != 8'd0) && (cur.length == len_r) &&
                (cur.code == acc_r);
  assign stop = (cur.symbol == 8'd0) || hit || (slot_r == IDX_W'(TABLE_DEPTH - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      vld_r      <= '0;
      acc_r      <= '0;
      len_r      <= '0;
      pend_vld_r <= 1'b0;
      eom_r      <= 1'b0;
      left_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      acc_r      <= acc_nxt;
      len_r      <= len_nxt;
      pend_vld_r <= pend_vld_nxt;
      eom_r      <= eom_nxt;
      left_r     <= left_nxt;
      if (wr_en) vld_r[op.index] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    slot_r <= slot_nxt;
    res_r  <= res_nxt;
    pend_r <= pend_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    acc_nxt      = acc_r;
    len_nxt      = len_r;
    byte_nxt     = byte_r;
    left_nxt     = left_r;
    eom_nxt      = eom_r;
    slot_nxt     = slot_r;
    res_nxt      = res_r;
    pend_nxt     = pend_r;
    pend_vld_nxt = pend_vld_r;
    op_pop       = 1'b0;
    wr_en        = 1'b0;
    q_push       = 1'b0;
    rd_addr      = slot_r + IDX_W'(1);
    q_word       = pend_r;
    q_word.last  = (state_r == ST_FLUSH);

    case (state_r)
      ST_IDLE: begin
        if (op_valid) begin
          op_pop = 1'b1;
          case (op.kind)
            OP_LOAD: begin
              wr_en = 1'b1;
            end
            OP_DECODE: begin
              byte_nxt  = op.code_byte;
              left_nxt  = op.bit_count;
              eom_nxt   = op.eom;
              state_nxt = ST_NEXT_BIT;
            end
            default: begin
            end
          endcase
        end
      end

      ST_NEXT_BIT: begin
        rd_addr = IDX_W'(1);
        if (left_r != '0) begin
          acc_nxt   = {acc_r[MAX_CODE_BITS-2:0], byte_r[BYTE_BITS-1]};
          len_nxt   = len_r + LEN_W'(1);
          byte_nxt  = byte_r << 1;
          left_nxt  = left_r - CNT_W'(1);
          slot_nxt  = IDX_W'(1);
          state_nxt = ST_SCAN;
        end else if (eom_r) begin
          eom_nxt   = 1'b0;
          acc_nxt   = '0;
          len_nxt   = '0;
          res_nxt   = '{symbol: 8'd0, message_end: 1'b1, code_overflow: 1'b0, last: 1'b0};
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_FLUSH;
        end
      end

      ST_SCAN: begin
        if (hit) begin
          res_nxt   = '{symbol: cur.symbol, message_end: 1'b0, code_overflow: 1'b0,
                        last: 1'b0};
          acc_nxt   = '0;
          len_nxt   = '0;
          state_nxt = ST_EMIT;
        end else if (stop) begin
          if (len_r >= LEN_W'(MAX_CODE_BITS)) begin
            res_nxt   = '{symbol: 8'd0, message_end: 1'b0, code_overflow: 1'b1,
                          last: 1'b0};
            acc_nxt   = '0;
            len_nxt   = '0;
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_NEXT_BIT;
          end
        end else begin
          slot_nxt = slot_r + IDX_W'(1);
        end
      end

      // hold one result back so the item's final result can carry last
      ST_EMIT: begin
        if (!pend_vld_r || !q_full) begin
          q_push       = pend_vld_r;
          pend_nxt     = res_r;
          pend_vld_nxt = 1'b1;
          state_nxt    = ST_NEXT_BIT;
        end
      end

      ST_FLUSH: begin
        if (!pend_vld_r) begin
          state_nxt = ST_IDLE;
        end else if (!q_full) begin
          q_push       = 1'b1;
          pend_vld_nxt = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
